FILE: rtl/core/tcpop_pkg.sv
`default_nettype none

package tcpop_pkg;

   // One request: a single byte of the TCP option region.
   typedef struct packed {
      logic [7:0] option_byte;
      logic [3:0] data_offset;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   // One result: the verdict of a segment and the options it carried.
   typedef struct packed {
      logic        verdict;
      logic [15:0] max_segment_size;
      logic [3:0]  window_scale;
   } rsp_type;

   // A classified request, handed from the front part to the parser.
   typedef struct packed {
      logic [7:0] option_byte;
      logic [5:0] position;
      logic [5:0] region_len;
      logic       in_region;
      logic       bad_offset;
      logic       first_byte;
      logic       last_byte;
   } work_type;

   localparam logic [2:0] PH_KIND   = 3'd0;
   localparam logic [2:0] PH_LEN    = 3'd1;
   localparam logic [2:0] PH_DATA_A = 3'd2;
   localparam logic [2:0] PH_DATA_B = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_WSCALE = 2'd1;
   localparam logic [1:0] KIND_MSS    = 2'd2;
   localparam logic [1:0] KIND_OTHER  = 2'd3;

   localparam logic [7:0] OPT_EOL    = 8'd0;
   localparam logic [7:0] OPT_NOP    = 8'd1;
   localparam logic [7:0] OPT_MSS    = 8'd2;
   localparam logic [7:0] OPT_WSCALE = 8'd3;

   localparam logic [7:0] LEN_WSCALE = 8'd3;
   localparam logic [7:0] LEN_MSS    = 8'd4;
   localparam logic [7:0] LEN_MIN    = 8'd2;
   localparam logic [7:0] WSCALE_MAX = 8'd14;

   localparam logic [3:0] MIN_DATA_OFFSET = 4'd5;
   localparam logic [6:0] BASE_HDR_BYTES  = 7'd20;
   localparam logic [5:0] POSITION_MAX    = 6'd63;

endpackage

`default_nettype wire

FILE: rtl/core/tcpop_queue.sv
`default_nettype none

module tcpop_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcpop_front.sv
`default_nettype none

module tcpop_front
   import tcpop_pkg::*;
#(
   parameter int MAX_OPTION_BYTES = 40
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire logic    accept,
   output work_type     work_data
);

   logic [5:0] position_ff, position_in;
   logic [5:0] position;
   logic [6:0] raw_len;
   logic       bad_offset;

   // Position within the segment; a first request restarts it.
   assign position = req_data.first_byte ? '0 : position_ff;

   always_comb begin
      raw_len    = {1'b0, req_data.data_offset, 2'b00} - BASE_HDR_BYTES;
      bad_offset = (req_data.data_offset < MIN_DATA_OFFSET) ||
                   (raw_len > 7'(MAX_OPTION_BYTES));

      work_data.option_byte = req_data.option_byte;
      work_data.position    = position;
      work_data.region_len  = bad_offset ? '0 : raw_len[5:0];
      work_data.in_region   = !bad_offset && ({1'b0, position} < raw_len);
      work_data.bad_offset  = bad_offset;
      work_data.first_byte  = req_data.first_byte;
      work_data.last_byte   = req_data.last_byte;

      position_in = position_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            position_in = '0;
         end else if (position != POSITION_MAX) begin
            position_in = position + 1'b1;
         end else begin
            position_in = position;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else begin
         position_ff <= position_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcpop_back.sv
`default_nettype none

module tcpop_back
   import tcpop_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire work_type work_data,
   input  wire logic     work_empty,
   output logic          work_pop,
   output rsp_type       rsp_data,
   output logic          rsp_push,
   input  wire logic     rsp_full
);

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  skip_ff, skip_in;
   logic [15:0] mss_ff, mss_in;
   logic [3:0]  wscale_ff, wscale_in;
   logic        drop_ff, drop_in;
   logic [8:0]  option_end;
   logic [7:0]  b;

   assign work_pop = !work_empty && !rsp_full;
   assign rsp_push = work_pop && work_data.last_byte;
   assign b        = work_data.option_byte;

   // End of an unknown option: the kind byte sits one before this length byte.
   assign option_end = {3'b000, work_data.position} - 9'd1 + {1'b0, b};

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      skip_in   = skip_ff;
      mss_in    = mss_ff;
      wscale_in = wscale_ff;
      drop_in   = drop_ff;

      if (work_data.first_byte) begin
         phase_in  = PH_KIND;
         kind_in   = KIND_NONE;
         skip_in   = '0;
         mss_in    = '0;
         wscale_in = '0;
         drop_in   = 1'b0;
      end

      if (work_data.in_region && !drop_in) begin
         case (phase_in)
            PH_LEN: begin
               if (kind_in == KIND_WSCALE) begin
                  if (b != LEN_WSCALE) drop_in = 1'b1;
                  else phase_in = PH_DATA_A;
               end else if (kind_in == KIND_MSS) begin
                  if (b != LEN_MSS) drop_in = 1'b1;
                  else phase_in = PH_DATA_A;
               end else if (b < LEN_MIN ||
                            option_end > {3'b000, work_data.region_len}) begin
                  drop_in = 1'b1;
               end else begin
                  skip_in  = b - LEN_MIN;
                  phase_in = (b != LEN_MIN) ? PH_SKIP : PH_KIND;
               end
            end
            PH_DATA_A: begin
               if (kind_in == KIND_WSCALE) begin
                  if (b > WSCALE_MAX) begin
                     drop_in = 1'b1;
                  end else begin
                     wscale_in = b[3:0];
                     phase_in  = PH_KIND;
                  end
               end else begin
                  mss_in   = {b, 8'h00};
                  phase_in = PH_DATA_B;
               end
            end
            PH_DATA_B: begin
               mss_in   = {mss_in[15:8], b};
               phase_in = PH_KIND;
            end
            PH_SKIP: begin
               skip_in = skip_in - 1'b1;
               if (skip_in == '0) phase_in = PH_KIND;
            end
            default: begin
               phase_in = PH_KIND;
               if (b == OPT_WSCALE) begin
                  kind_in  = KIND_WSCALE;
                  phase_in = PH_LEN;
               end else if (b == OPT_MSS) begin
                  kind_in  = KIND_MSS;
                  phase_in = PH_LEN;
               end else if (b != OPT_EOL && b != OPT_NOP) begin
                  kind_in  = KIND_OTHER;
                  phase_in = PH_LEN;
               end
            end
         endcase
      end

      // A segment ending mid-option gets zero bytes; a missing length drops it.
      if (work_data.last_byte && !drop_in) begin
         case (phase_in)
            PH_LEN:    drop_in = 1'b1;
            PH_DATA_A: begin
               if (kind_in == KIND_WSCALE) wscale_in = '0;
               else mss_in = '0;
            end
            PH_DATA_B: mss_in = {mss_in[15:8], 8'h00};
            default:   ;
         endcase
      end

      rsp_data.verdict          = work_data.bad_offset || drop_in;
      rsp_data.max_segment_size = mss_in;
      rsp_data.window_scale     = wscale_in;

      if (work_data.last_byte) begin
         phase_in  = PH_KIND;
         kind_in   = KIND_NONE;
         skip_in   = '0;
         mss_in    = '0;
         wscale_in = '0;
         drop_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_KIND;
         kind_ff   <= KIND_NONE;
         skip_ff   <= '0;
         mss_ff    <= '0;
         wscale_ff <= '0;
         drop_ff   <= 1'b0;
      end else if (work_pop) begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         skip_ff   <= skip_in;
         mss_ff    <= mss_in;
         wscale_ff <= wscale_in;
         drop_ff   <= drop_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcp_option_parser_unit.sv
// TCP option parser, extracting the MSS and window scale options.
//
// Requests arrive on a queue-style port: one option byte per request, with the
// header data offset and first/last markers. A request is taken at a rising
// edge with req_push high and req_full low. Each request that carries
// last_byte yields one result, which waits on rsp_data while rsp_empty is low
// and is taken at an edge with rsp_pop high; other requests yield nothing.
//
// The front part assigns each byte its position in the segment and works out
// the option region length, then writes the classified byte into a short
// queue. The back part parses one byte per cycle while the result queue
// has room, writing results into a second queue. One request is taken per
// cycle unless the receiver stalls; the last byte is queued, then its result.
//
// When the receiver stalls, the result queue fills, the parser stops, the
// front queue fills and req_full rises, so nothing is lost. Synchronous reset
// empties both queues and returns the parser to waiting for an option kind,
// with no captured options and no drop pending.
`default_nettype none

module tcp_option_parser_unit
   import tcpop_pkg::*;
#(
   parameter int MAX_OPTION_BYTES = 40,
   parameter int QUEUE_DEPTH      = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   output logic         req_full,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data,
   output logic         rsp_empty
);

   work_type work_in, work_out;
   logic     work_empty, work_pop;
   rsp_type  result;
   logic     result_push, result_full;
   logic     accept;

   assign accept = req_push && !req_full;

   tcpop_front #(
      .MAX_OPTION_BYTES(MAX_OPTION_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .accept    (accept),
      .work_data (work_in)
   );

   tcpop_queue #(
      .WIDTH($bits(work_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_work_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (work_in),
      .full      (req_full),
      .pop       (work_pop),
      .pop_data  (work_out),
      .empty     (work_empty)
   );

   tcpop_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_data  (work_out),
      .work_empty (work_empty),
      .work_pop   (work_pop),
      .rsp_data   (result),
      .rsp_push   (result_push),
      .rsp_full   (result_full)
   );

   tcpop_queue #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

`default_nettype wire

FILE: rtl/core/tcpop_checker.sv
`default_nettype none

module tcpop_checker
   import tcpop_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_push,
   input wire req_type req_data,
   input wire logic    req_full,
   input wire logic    rsp_pop,
   input wire rsp_type rsp_data,
   input wire logic    rsp_empty
);

   // Reset leaves no result behind.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting straight after reset");

   // Reset frees the request side.
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full straight after reset");

   // A waiting result holds until it is popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before it was popped");

   // A captured window scale never exceeds the largest legal shift.
   a_wscale_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.window_scale <= WSCALE_MAX[3:0]))
      else $error("window scale out of range");

endmodule

bind tcp_option_parser_unit tcpop_checker u_tcpop_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_data  (req_data),
   .req_full  (req_full),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data),
   .rsp_empty (rsp_empty)
);

`default_nettype wire

FILE: tb/option_verdict_checker.sv
module option_verdict_checker
   import tcpop_pkg::*;
#(
   parameter int MAX_OPTION_BYTES = 40
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   input  wire logic    req_full,
   input  wire logic    rsp_pop,
   input  wire rsp_type rsp_data,
   input  wire logic    rsp_empty,
   output int           fail_count,
   output int           verdicts_waiting,
   output int           verdicts_checked,
   output int           requests_taken,
   output int           drops_checked
);

   // Parser state of the segment now arriving.
   logic [5:0]  seg_position;
   logic [2:0]  phase;
   logic [1:0]  opt_kind;
   logic [7:0]  skip_left;
   logic [15:0] mss_value;
   logic [3:0]  wscale_value;
   logic        seg_dropped;

   rsp_type verdict_queue[$];
   int      mismatches;
   int      checked;
   int      taken;
   int      drops;

   task automatic clear_segment();
      seg_position = '0;
      phase        = PH_KIND;
      opt_kind     = KIND_NONE;
      skip_left    = '0;
      mss_value    = '0;
      wscale_value = '0;
      seg_dropped  = 1'b0;
   endtask

   task automatic parse_option_byte(input logic [7:0] b, input int pos, input int region);
      case (phase)
         PH_LEN: begin
            if (opt_kind == KIND_WSCALE) begin
               if (b != LEN_WSCALE) seg_dropped = 1'b1;
               else phase = PH_DATA_A;
            end else if (opt_kind == KIND_MSS) begin
               if (b != LEN_MSS) seg_dropped = 1'b1;
               else phase = PH_DATA_A;
            end else if (b < LEN_MIN || (pos - 1) + int'(b) > region) begin
               // The kind byte sat one place earlier; the option must end in the region.
               seg_dropped = 1'b1;
            end else begin
               skip_left = b - LEN_MIN;
               phase     = (skip_left != 0) ? PH_SKIP : PH_KIND;
            end
         end
         PH_DATA_A: begin
            if (opt_kind == KIND_WSCALE) begin
               if (b > WSCALE_MAX) begin
                  seg_dropped = 1'b1;
               end else begin
                  wscale_value = b[3:0];
                  phase        = PH_KIND;
               end
            end else begin
               mss_value = {b, 8'h00};
               phase     = PH_DATA_B;
            end
         end
         PH_DATA_B: begin
            mss_value[7:0] = b;
            phase          = PH_KIND;
         end
         PH_SKIP: begin
            skip_left = skip_left - 8'd1;
            if (skip_left == 0) phase = PH_KIND;
         end
         default: begin
            phase = PH_KIND;
            if (b == OPT_WSCALE) begin
               opt_kind = KIND_WSCALE;
               phase    = PH_LEN;
            end else if (b == OPT_MSS) begin
               opt_kind = KIND_MSS;
               phase    = PH_LEN;
            end else if (b > OPT_NOP) begin
               opt_kind = KIND_OTHER;
               phase    = PH_LEN;
            end
         end
      endcase
   endtask

   task automatic take_request(input req_type r);
      bit      bad;
      int      region;
      int      pos;
      rsp_type v;
      bad    = (r.data_offset < MIN_DATA_OFFSET);
      region = bad ? 0 : int'(r.data_offset) * 4 - int'(BASE_HDR_BYTES);
      if (region > MAX_OPTION_BYTES) bad = 1'b1;
      if (r.first_byte) clear_segment();
      pos = seg_position;
      if (!bad && !seg_dropped && pos < region) parse_option_byte(r.option_byte, pos, region);
      if (seg_position != POSITION_MAX) seg_position = seg_position + 6'd1;
      if (r.last_byte) begin
         // An option cut short reads its missing bytes as zero; a missing length byte drops the segment.
         if (!seg_dropped) begin
            case (phase)
               PH_LEN: seg_dropped = 1'b1;
               PH_DATA_A: begin
                  if (opt_kind == KIND_WSCALE) wscale_value = '0;
                  else mss_value = '0;
               end
               PH_DATA_B: mss_value[7:0] = '0;
               default: ;
            endcase
         end
         v.verdict          = bad || seg_dropped;
         v.max_segment_size = mss_value;
         v.window_scale     = wscale_value;
         verdict_queue.push_back(v);
         clear_segment();
      end
   endtask

   task automatic check_verdict(input rsp_type got);
      rsp_type want;
      if (verdict_queue.size() == 0) begin
         $error("unexpected verdict %0d, mss %0d, window scale %0d",
                got.verdict, got.max_segment_size, got.window_scale);
         mismatches++;
      end else begin
         want = verdict_queue.pop_front();
         checked++;
         if (want.verdict) drops++;
         if (got.verdict !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
            mismatches++;
         end
         if (got.max_segment_size !== want.max_segment_size) begin
            $error("max_segment_size: expected %0d, actual %0d",
                   want.max_segment_size, got.max_segment_size);
            mismatches++;
         end
         if (got.window_scale !== want.window_scale) begin
            $error("window_scale: expected %0d, actual %0d",
                   want.window_scale, got.window_scale);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_segment();
         verdict_queue.delete();
      end else begin
         if (req_push && !req_full) begin
            taken++;
            take_request(req_data);
         end
         if (rsp_pop && !rsp_empty) check_verdict(rsp_data);
      end
      fail_count       <= mismatches;
      verdicts_waiting <= verdict_queue.size();
      verdicts_checked <= checked;
      requests_taken   <= taken;
      drops_checked    <= drops;
   end

endmodule

FILE: tb/tcp_option_parser_unit_test.sv
// Top of the option parser test. It only makes stimulus and gives the verdict;
// prediction and comparison live in the checker instantiated beside the block.
module tcp_option_parser_unit_test;
   import tcpop_pkg::*;

   logic    clock;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;
   logic    rsp_empty;

   int fail_count;
   int verdicts_waiting;
   int verdicts_checked;
   int requests_taken;
   int drops_checked;

   // Sender pacing: requests go out in bursts, and between bursts the sender
   // pauses unless it is in a steady stretch, in which it never idles.
   int items_sent;
   int burst_left;
   bit steady;

   // The bytes of the segment being built, sent in order by emit_segment.
   logic [7:0] seg_bytes[$];

   // Receiver pacing state.
   int          pop_window;
   int          pop_mode;
   logic [15:0] pop_pattern;
   logic [3:0]  pop_phase;

   tcp_option_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   option_verdict_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_data         (req_data),
      .req_full         (req_full),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .rsp_empty        (rsp_empty),
      .fail_count       (fail_count),
      .verdicts_waiting (verdicts_waiting),
      .verdicts_checked (verdicts_checked),
      .requests_taken   (requests_taken),
      .drops_checked    (drops_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver picks a way of stalling for a window of cycles at a time:
   // always ready, a random repeating pattern, a pop per phase counter wrap
   // (a long stall backing up to the request side), or a coin toss each cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (pop_window == 0) begin
            pop_mode    = $urandom_range(0, 3);
            pop_pattern = 16'($urandom);
            pop_window  = $urandom_range(16, 96);
         end else begin
            pop_window--;
         end
         case (pop_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= pop_pattern[pop_phase];
            2: rsp_pop <= (pop_phase == 0);
            default: rsp_pop <= 1'($urandom_range(0, 1));
         endcase
         pop_phase = pop_phase + 4'd1;
      end
   end

   // Offers one request and holds it until the block takes it. Acceptance is
   // judged on the value of req_full just before the edge. After it the sender
   // either keeps push high for the next request or takes a pause; in either
   // case push receives at most one assignment in this time step.
   task automatic send_request(input req_type r);
      req_data <= r;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 23);
         if (!steady) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // Sends the bytes in seg_bytes as one segment. The first and last markers
   // may be left off, and with jitter some requests carry a random data
   // offset instead of the segment's own.
   task automatic emit_segment(input logic [3:0] doff, input bit with_first,
                               input bit with_last, input bit jitter);
      req_type r;
      int      count;
      count = seg_bytes.size();
      for (int i = 0; i < count; i++) begin
         r.option_byte = seg_bytes[i];
         r.data_offset = (jitter && $urandom_range(0, 3) == 0) ?
                         4'($urandom_range(0, 15)) : doff;
         r.first_byte  = with_first && (i == 0);
         r.last_byte   = with_last && (i == count - 1);
         send_request(r);
      end
   endtask

   // Appends well-formed options with random content until the region is full.
   task automatic fill_options(input int region);
      int room;
      int pick;
      int olen;
      while (seg_bytes.size() < region) begin
         room = region - seg_bytes.size();
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            seg_bytes.push_back(OPT_EOL);
         end else if (pick <= 2) begin
            seg_bytes.push_back(OPT_NOP);
         end else if (pick <= 4 && room >= 4) begin
            seg_bytes.push_back(OPT_MSS);
            seg_bytes.push_back(LEN_MSS);
            seg_bytes.push_back(8'($urandom_range(0, 255)));
            seg_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick <= 6 && room >= 3) begin
            seg_bytes.push_back(OPT_WSCALE);
            seg_bytes.push_back(LEN_WSCALE);
            seg_bytes.push_back(8'($urandom_range(0, 14)));
         end else if (pick >= 7 && room >= 2) begin
            // An unknown kind whose length may run right up to the region end.
            olen = $urandom_range(2, (room < 12) ? room : 12);
            seg_bytes.push_back(8'($urandom_range(4, 255)));
            seg_bytes.push_back(8'(olen));
            repeat (olen - 2) seg_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            seg_bytes.push_back(OPT_NOP);
         end
      end
   endtask

   initial begin
      int         pick;
      int         shape;
      int         region;
      int         target;
      logic [3:0] doff;

      items_sent = 0;
      burst_left = 0;
      steady     = 1'b0;
      pop_window = 0;
      pop_mode   = 0;
      pop_phase  = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed segments. An offset below five has no option region, so the
      // segment is dropped whatever its bytes are.
      seg_bytes = '{8'hA5};
      emit_segment(4'd4, 1'b1, 1'b1, 1'b0);
      seg_bytes = '{8'h00};
      emit_segment(4'd0, 1'b1, 1'b1, 1'b0);
      // An offset of five means an empty region: the byte is ignored.
      seg_bytes = '{8'hFF};
      emit_segment(MIN_DATA_OFFSET, 1'b1, 1'b1, 1'b0);
      // Largest MSS and largest legal shift, followed by padding.
      seg_bytes = '{OPT_MSS, LEN_MSS, 8'hFF, 8'hFF, OPT_WSCALE, LEN_WSCALE,
                    WSCALE_MAX, OPT_NOP};
      emit_segment(4'd7, 1'b1, 1'b1, 1'b0);
      // A shift one above the limit is dropped.
      seg_bytes = '{OPT_WSCALE, LEN_WSCALE, WSCALE_MAX + 8'd1, OPT_EOL};
      emit_segment(4'd6, 1'b1, 1'b1, 1'b0);
      // An unknown option whose length runs past the region.
      seg_bytes = '{8'hFE, 8'hFF};
      emit_segment(4'd6, 1'b1, 1'b1, 1'b0);
      // The segment stops half way through the MSS value.
      seg_bytes = '{OPT_MSS, LEN_MSS, 8'h12};
      emit_segment(4'd15, 1'b1, 1'b1, 1'b0);
      // The segment stops while a length byte is awaited.
      seg_bytes = '{OPT_MSS};
      emit_segment(4'd6, 1'b1, 1'b1, 1'b0);
      // No first marker: the previous result must already have cleared state.
      seg_bytes = '{OPT_NOP, OPT_WSCALE};
      emit_segment(4'd6, 1'b0, 1'b1, 1'b0);

      // Random segments: mostly well-formed option lists with random content,
      // some cut short, overrun or corrupted, and the rest plain noise.
      while (items_sent < 1950) begin
         if ($urandom_range(0, 14) == 0) steady = !steady;
         seg_bytes.delete();
         pick = $urandom_range(0, 99);
         if (pick == 0) begin
            // Long enough for the byte position to saturate.
            fill_options(40);
            target = $urandom_range(64, 72);
            while (seg_bytes.size() < target) seg_bytes.push_back(8'($urandom_range(0, 255)));
            emit_segment(4'd15, 1'b1, 1'b1, 1'b0);
         end else if (pick < 76) begin
            doff   = 4'($urandom_range(5, 15));
            region = int'(doff) * 4 - int'(BASE_HDR_BYTES);
            fill_options(region);
            shape = $urandom_range(0, 9);
            if (region == 0) begin
               seg_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (shape == 0 && region > 1) begin
               target    = $urandom_range(1, region - 1);
               seg_bytes = seg_bytes[0:target - 1];
            end else if (shape == 1) begin
               repeat ($urandom_range(1, 6)) seg_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 7) == 0)
               seg_bytes[$urandom_range(0, seg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            emit_segment(doff, $urandom_range(0, 19) != 0, 1'b1, $urandom_range(0, 24) == 0);
         end else begin
            doff = 4'($urandom_range(0, 15));
            repeat ($urandom_range(1, 10)) seg_bytes.push_back(8'($urandom_range(0, 255)));
            emit_segment(doff, $urandom_range(0, 3) != 0, $urandom_range(0, 7) != 0,
                         $urandom_range(0, 3) == 0);
         end
      end
      req_push <= 1'b0;

      // Let the checker's count include the last request taken, then wait for
      // every verdict to drain and wait on for any stray result to show up.
      @(posedge clock);
      while (verdicts_waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d requests and %0d segment verdicts, %0d of them drops.",
               requests_taken, verdicts_checked, drops_checked);
      if (fail_count == 0 && verdicts_waiting == 0) begin
         $display("tcp_option_parser_unit_test: PASS");
      end else begin
         $display("tcp_option_parser_unit_test: FAIL");
      end
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #(12 * 400000);
      $display("tcp_option_parser_unit_test: FAIL");
      $finish;
   end

endmodule
